/* sv/bce_pkg.sv */
// Package for the battery charge estimator: gain constants, breakpoint and
// charge tables, and the widths shared by the pipeline.
// No dependencies.
package bce_pkg;

    localparam int RAW_W     = 16;
    localparam int VOLT_W    = 10;
    localparam int PCT_W     = 7;
    localparam int GAIN_W    = 14;
    localparam int PROD_W    = RAW_W + GAIN_W;
    localparam int GAIN_SHIFT = 20;

    localparam logic [GAIN_W-1:0] GAIN_MULT = 14'd12006;

    // Curve length in use and the size of the breakpoint table behind it
    localparam int CURVE_POINTS = 8;
    localparam int TABLE_SLOTS  = 16;
    localparam int SEG_W        = $clog2(TABLE_SLOTS);

    // Offset into a segment never exceeds its span; the default table spans at most 40
    localparam int OFS_W        = 7;
    localparam int RISE_PROD_W  = PCT_W + OFS_W;
    localparam int RECIP_SHIFT  = 20;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int QPROD_W      = RISE_PROD_W + RECIP_W;

    localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

    typedef logic [VOLT_W-1:0] volt_t;
    typedef logic [PCT_W-1:0]  pct_t;

    localparam volt_t BP_VOLTS [TABLE_SLOTS] = '{
        10'd300, 10'd290, 10'd280, 10'd270, 10'd260, 10'd250, 10'd240, 10'd200,
        10'd200, 10'd200, 10'd200, 10'd200, 10'd200, 10'd200, 10'd200, 10'd200
    };

    localparam pct_t BP_CHARGE [TABLE_SLOTS] = '{
        7'd100, 7'd78, 7'd59, 7'd37, 7'd26, 7'd13, 7'd0, 7'd0,
        7'd0,   7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0
    };

endpackage

/* sv/battery_charge_estimator_unit.sv */
// Battery charge estimator top level: four-stage pipeline from raw sample to
// centivolts and charge percent. Depends on bce_pkg.
//
// Takes one left-aligned 16-bit supply sample per cycle and returns its
// voltage in hundredths of a volt, (raw_sample * 12006) >> 20, with the
// charge percent read off a piecewise-linear curve of descending
// breakpoints: 100 above the top point, 0 at or below the last, truncated
// linear interpolation in between. The pipeline has four register stages
// (gain multiply, breakpoint search, rise times offset, reciprocal multiply
// for the constant span and add); one item is taken every cycle while the
// result side does not stall.
// A stall on the result side holds each full stage whose later stages are
// all full; the other stages keep advancing.
module battery_charge_estimator_unit
    import bce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  logic [RAW_W-1:0]  raw_sample,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [VOLT_W-1:0] supply_centivolts,
    output logic [PCT_W-1:0]  charge_percent
);

    localparam int LIMIT = (CURVE_POINTS > TABLE_SLOTS) ? TABLE_SLOTS : CURVE_POINTS;

    // Per-segment rise and span reciprocal; entry i is the segment below point i-1
    pct_t                rise_tab  [TABLE_SLOTS];
    logic [RECIP_W-1:0]  recip_tab [TABLE_SLOTS];

    assign rise_tab[0]  = '0;
    assign recip_tab[0] = '0;

    for (genvar g = 1; g < TABLE_SLOTS; g++)
    begin : g_seg
        localparam int SPAN  = int'(BP_VOLTS[g-1]) - int'(BP_VOLTS[g]);
        localparam int RECIP = (SPAN <= 0) ? 0 :
                               ((1 << RECIP_SHIFT) + SPAN - 1) / ((SPAN <= 0) ? 1 : SPAN);
        localparam int RISE  = (BP_CHARGE[g-1] >= BP_CHARGE[g]) ?
                               int'(BP_CHARGE[g-1]) - int'(BP_CHARGE[g]) : 0;
        assign rise_tab[g]  = PCT_W'(RISE);
        assign recip_tab[g] = RECIP_W'(RECIP);
    end

    // Stage valid bits and advance enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_adv, s2_adv, s3_adv, s4_adv;

    assign s4_adv = !s4_valid_reg || !result_stall;
    assign s3_adv = !s3_valid_reg || s4_adv;
    assign s2_adv = !s2_valid_reg || s3_adv;
    assign s1_adv = !s1_valid_reg || s2_adv;

    assign sample_stall = !s1_adv;

    // Stage 1: gain multiply
    logic [PROD_W-1:0] prod_reg, prod_next;
    assign prod_next = PROD_W'(raw_sample) * PROD_W'(GAIN_MULT);

    // Stage 2: breakpoint search
    volt_t              volt2_reg, volt2_next;
    volt_t              volt3_reg, volt4_reg;
    pct_t               base2_reg, base2_next, base3_reg;
    pct_t               rise2_reg, rise2_next;
    logic [OFS_W-1:0]   ofs2_reg, ofs2_next;
    logic [RECIP_W-1:0] recip2_reg, recip2_next, recip3_reg;
    logic [RISE_PROD_W-1:0] rp3_reg, rp3_next;
    pct_t               pct4_reg, pct4_next;
    logic [QPROD_W-1:0] qprod;
    logic [PCT_W:0]     pct_sum;

    logic              found;
    logic [SEG_W-1:0]  seg;
    volt_t             diff;

    always_comb
    begin
        found = 1'b0;
        seg   = '0;
        volt2_next = prod_reg[GAIN_SHIFT +: VOLT_W];
        for (int i = 0; i < LIMIT; i++)
        begin
            if (!found && (volt2_next > BP_VOLTS[i]))
            begin
                found = 1'b1;
                seg   = SEG_W'(i);
            end
        end
        diff = volt2_next - BP_VOLTS[seg];
        if (!found)
        begin
            base2_next  = '0;
            rise2_next  = '0;
            recip2_next = '0;
        end
        else if (seg == '0)
        begin
            base2_next  = FULL_PERCENT;
            rise2_next  = '0;
            recip2_next = '0;
        end
        else
        begin
            base2_next  = BP_CHARGE[seg];
            rise2_next  = rise_tab[seg];
            recip2_next = recip_tab[seg];
        end
        ofs2_next = diff[OFS_W-1:0];
    end

    // Stage 3: rise times offset
    assign rp3_next = RISE_PROD_W'(rise2_reg) * RISE_PROD_W'(ofs2_reg);

    // Stage 4: divide by span through its reciprocal, then add the segment base
    assign qprod     = QPROD_W'(rp3_reg) * QPROD_W'(recip3_reg);
    assign pct_sum   = {1'b0, base3_reg} + {1'b0, qprod[RECIP_SHIFT +: PCT_W]};
    assign pct4_next = pct_sum[PCT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv) s1_valid_reg <= sample_valid;
            if (s2_adv) s2_valid_reg <= s1_valid_reg;
            if (s3_adv) s3_valid_reg <= s2_valid_reg;
            if (s4_adv) s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            prod_reg <= prod_next;
        end
        if (s2_adv)
        begin
            volt2_reg  <= volt2_next;
            base2_reg  <= base2_next;
            rise2_reg  <= rise2_next;
            ofs2_reg   <= ofs2_next;
            recip2_reg <= recip2_next;
        end
        if (s3_adv)
        begin
            volt3_reg  <= volt2_reg;
            base3_reg  <= base2_reg;
            recip3_reg <= recip2_reg;
            rp3_reg    <= rp3_next;
        end
        if (s4_adv)
        begin
            volt4_reg <= volt3_reg;
            pct4_reg  <= pct4_next;
        end
    end

    assign result_valid      = s4_valid_reg;
    assign supply_centivolts = volt4_reg;
    assign charge_percent    = pct4_reg;

endmodule

/* dv/tb.sv */
// Self-checking testbench for battery_charge_estimator_unit: a scoreboard class
// predicts centivolts and charge for each accepted sample; tasks drive the item.
// Depends on bce_pkg and the battery_charge_estimator_unit RTL.
module tb
    import bce_pkg::*;
();

    typedef struct packed {
        volt_t volts;
        pct_t  pct;
    } reading_t;

    class charge_scoreboard;
        reading_t pending_readings[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Scale, then walk the descending breakpoints for the first one exceeded
        function reading_t predict_reading(logic [RAW_W-1:0] raw);
            reading_t   r;
            longint     prod;
            int         cv;
            int         span;
            int         rise;
            bit         found;
            prod  = longint'(raw) * 12006;
            cv    = int'(prod >> 20);
            r.volts = volt_t'(cv);
            r.pct   = '0;
            found   = 0;
            for (int i = 0; i < CURVE_POINTS && !found; i++)
            begin
                if (cv > int'(BP_VOLTS[i]))
                begin
                    found = 1;
                    if (i == 0)
                    begin
                        r.pct = FULL_PERCENT;
                    end
                    else
                    begin
                        span = int'(BP_VOLTS[i-1]) - int'(BP_VOLTS[i]);
                        if (span == 0)
                        begin
                            r.pct = BP_CHARGE[i];
                        end
                        else
                        begin
                            rise = (BP_CHARGE[i-1] >= BP_CHARGE[i]) ?
                                   int'(BP_CHARGE[i-1]) - int'(BP_CHARGE[i]) : 0;
                            r.pct = pct_t'(int'(BP_CHARGE[i]) +
                                    (rise * (cv - int'(BP_VOLTS[i]))) / span);
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note_sample(logic [RAW_W-1:0] raw);
            pending_readings.push_back(predict_reading(raw));
        endfunction

        function void check_result(volt_t volts, pct_t pct);
            reading_t want;
            if (pending_readings.size() == 0)
            begin
                $error("unexpected result: supply_centivolts=%0d charge_percent=%0d",
                       volts, pct);
                mismatches++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (volts !== want.volts)
                begin
                    $error("supply_centivolts: expected %0d, actual %0d", want.volts, volts);
                    mismatches++;
                end
                if (pct !== want.pct)
                begin
                    $error("charge_percent: expected %0d, actual %0d", want.pct, pct);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_stall;
    logic [RAW_W-1:0]  raw_sample;
    logic              result_valid;
    logic              result_stall;
    logic [VOLT_W-1:0] supply_centivolts;
    logic [PCT_W-1:0]  charge_percent;

    charge_scoreboard sb;
    bit               steady_run;

    battery_charge_estimator_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .raw_sample        (raw_sample),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .supply_centivolts (supply_centivolts),
        .charge_percent    (charge_percent)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Smallest raw sample whose scaled voltage reaches cv
    function automatic logic [RAW_W-1:0] raw_reaching(int cv);
        longint r;
        r = (longint'(cv) * 1048576 + 12005) / 12006;
        if (r > 65535)
            r = 65535;
        return r[RAW_W-1:0];
    endfunction

    task automatic send_sample(input logic [RAW_W-1:0] raw);
        @(negedge clk);
        while (!steady_run && $urandom_range(99) < 19)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        raw_sample   <= raw;
        // Hold the item until it is taken
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sb.note_sample(raw);
    endtask

    always @(negedge clk)
    begin
        result_stall <= rst_n && !steady_run && ($urandom_range(99) < 19);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(supply_centivolts, charge_percent);
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [RAW_W-1:0] raw;
        logic [RAW_W-1:0] band_lo;
        logic [RAW_W-1:0] band_hi;
        int               guard;
        sb           = new();
        steady_run   = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        raw_sample   = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Zero, full scale and a few bit patterns
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        // Exactly on each breakpoint, then just above it
        for (int i = 0; i < CURVE_POINTS; i++)
        begin
            send_sample(raw_reaching(int'(BP_VOLTS[i])));
            send_sample(raw_reaching(int'(BP_VOLTS[i]) + 1));
        end

        // Weight the random part towards the curve region
        band_lo = raw_reaching(190);
        band_hi = raw_reaching(310);
        for (int n = 0; n < 650; n++)
        begin
            steady_run = (n >= 250 && n < 370);
            if ($urandom_range(99) < 75)
                raw = RAW_W'($urandom_range(band_hi, band_lo));
            else
                raw = RAW_W'($urandom);
            send_sample(raw);
        end
        steady_run = 1'b0;
        @(negedge clk);
        sample_valid <= 1'b0;

        guard = 0;
        while (sb.pending_readings.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.pending_readings.size() != 0)
        begin
            $display("TEST FAILED");
        end
        else
        begin
            repeat (10) @(posedge clk);
            if (sb.mismatches == 0)
                $display("TEST PASSED");
            else
                $display("TEST FAILED");
        end
        $finish;
    end

endmodule
